// ===== rtl/core/vspd_pkg.sv =====
// shared types, widths and codes for the vision steering pid drive
// no dependencies; imported by every module of the block

package vspd_pkg;

    localparam int OP_W       = 1;
    localparam int TGT_W      = 2;
    localparam int X_W        = 9;
    localparam int POS_W      = 20;
    localparam int RANGE_W    = 10;
    localparam int DRIVE_W    = 16;
    localparam int REASON_W   = 2;

    localparam int GAIN_W     = 18;
    localparam int SPEED_W    = 16;
    localparam int DIST_W     = 19;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam int TICK_W     = 17;
    localparam int INTEG_W    = 24;
    localparam int OFF_W      = 10;
    localparam int DIFF_W     = OFF_W + 1;
    localparam int TURN_W     = 18;
    localparam int FAC_W      = 20;
    localparam int TURN_LIM   = 65536;

    localparam int IMAGE_CENTER_DEF      = 160;
    localparam int MIN_TRUSTED_RANGE_DEF = 15;

    // digit-serial multiplier
    localparam int MUL_M_W   = 18;
    localparam int DIG_W     = 4;
    localparam int MUL_SH_W  = 24;
    localparam int MUL_P_W   = MUL_M_W + MUL_SH_W;
    localparam int MUL_CNT_W = 3;
    localparam int SUM_W     = MUL_P_W + 2;

    localparam logic [MUL_CNT_W-1:0] DIGS_OFF   = MUL_CNT_W'(3);
    localparam logic [MUL_CNT_W-1:0] DIGS_INTEG = MUL_CNT_W'(MUL_SH_W / DIG_W);
    localparam logic [MUL_CNT_W-1:0] DIGS_FAC   = MUL_CNT_W'(FAC_W / DIG_W);

    typedef enum logic [OP_W-1:0] {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic [REASON_W-1:0] {
        REASON_RUN     = 2'd0,
        REASON_DIST    = 2'd1,
        REASON_RANGE   = 2'd2,
        REASON_TIMEOUT = 2'd3
    } t_reason;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP    = 3'd0,
        CFG_INTEG   = 3'd1,
        CFG_DERIV   = 3'd2,
        CFG_SPEED   = 3'd3,
        CFG_MAXDIST = 3'd4,
        CFG_STOPRNG = 3'd5,
        CFG_TIMEOUT = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_INTEG,
        S_MUL_START,
        S_MUL_WAIT,
        S_TURN,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        TERM_PROP,
        TERM_INTEG,
        TERM_DERIV,
        TERM_LEFT,
        TERM_RIGHT
    } t_term;

    typedef struct packed {
        logic [GAIN_W-1:0]    prop_gain;
        logic [GAIN_W-1:0]    integ_gain;
        logic [GAIN_W-1:0]    deriv_gain;
        logic [SPEED_W-1:0]   base_speed;
        logic [DIST_W-1:0]    max_distance;
        logic [RANGE_W-1:0]   stop_range;
        logic [TIMEOUT_W-1:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [MUL_M_W-1:0]   multiplicand;
        logic [MUL_SH_W-1:0]  operand;
        logic [MUL_CNT_W-1:0] digits;
    } t_mul_req;

endpackage

// ===== rtl/core/vspd_cfg_regs.sv =====
// configuration register file, one write port
// depends on vspd_pkg

module vspd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [vspd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vspd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output vspd_pkg::t_cfg                o_cfg
);
    import vspd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PROP:    n_cfg.prop_gain     = i_cfg_data[GAIN_W-1:0];
                CFG_INTEG:   n_cfg.integ_gain    = i_cfg_data[GAIN_W-1:0];
                CFG_DERIV:   n_cfg.deriv_gain    = i_cfg_data[GAIN_W-1:0];
                CFG_SPEED:   n_cfg.base_speed    = i_cfg_data[SPEED_W-1:0];
                CFG_MAXDIST: n_cfg.max_distance  = i_cfg_data[DIST_W-1:0];
                CFG_STOPRNG: n_cfg.stop_range    = i_cfg_data[RANGE_W-1:0];
                CFG_TIMEOUT: n_cfg.timeout_ticks = i_cfg_data[TIMEOUT_W-1:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== rtl/core/vspd_digit_mult.sv =====
// digit-serial signed multiplier, msb digit first, 4 bits a cycle
// depends on vspd_pkg

module vspd_digit_mult (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vspd_pkg::t_mul_req                  i_req,
    output logic                                o_done,
    output logic signed [vspd_pkg::MUL_P_W-1:0] o_product
);
    import vspd_pkg::*;

    logic signed [MUL_M_W-1:0]     r_m;
    logic signed [MUL_M_W-1:0]     n_m;
    logic [MUL_SH_W-1:0]           r_sh;
    logic [MUL_SH_W-1:0]           n_sh;
    logic [MUL_CNT_W-1:0]          r_cnt;
    logic [MUL_CNT_W-1:0]          n_cnt;
    logic                          r_first;
    logic                          n_first;
    logic                          r_done;
    logic                          n_done;
    logic signed [MUL_P_W-1:0]     r_p;
    logic signed [MUL_P_W-1:0]     n_p;
    logic signed [DIG_W:0]         dig;
    logic signed [MUL_M_W+DIG_W:0] dprod;

    assign o_done    = r_done;
    assign o_product = r_p;

    // top digit carries the sign, the rest are unsigned
    always_comb begin
        if (r_first) begin
            dig = $signed({r_sh[MUL_SH_W-1], r_sh[MUL_SH_W-1 -: DIG_W]});
        end else begin
            dig = $signed({1'b0, r_sh[MUL_SH_W-1 -: DIG_W]});
        end
        dprod = r_m * dig;
    end

    always_comb begin
        n_m     = r_m;
        n_sh    = r_sh;
        n_cnt   = r_cnt;
        n_first = r_first;
        n_p     = r_p;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_m     = $signed(i_req.multiplicand);
            n_sh    = i_req.operand;
            n_cnt   = i_req.digits;
            n_first = 1'b1;
        end else if (r_cnt != '0) begin
            if (r_first) begin
                n_p = MUL_P_W'(dprod);
            end else begin
                n_p = (r_p <<< DIG_W) + MUL_P_W'(dprod);
            end
            n_sh    = r_sh << DIG_W;
            n_cnt   = r_cnt - MUL_CNT_W'(1);
            n_first = 1'b0;
            n_done  = (r_cnt == MUL_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_first <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_first <= n_first;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m  <= n_m;
        r_sh <= n_sh;
        r_p  <= n_p;
    end

endmodule

// ===== rtl/core/vision_steering_pid_drive.sv =====
// Vision steering drive: a start word opens a run, each tick word either stops the run
// (distance, trusted sonar range or timeout, in that priority; an untrusted near range still
// outranks timeout as the reason) or steers toward the target with a PID turn term and splits
// base speed into left and right Q1.15 drives. One word in gives one word out. Start, stop,
// finished and no-target ticks pass the evaluate and output states; a tick that steers on a
// target also uses the single 18 x 4 bit digit-serial multiplier that forms the three PID
// terms and the two drive products (22 digits in all, plus load and accumulate steps). The
// output register lets a new word be accepted while the last result is still stalled.

module vision_steering_pid_drive #(
    parameter int IMAGE_CENTER      = vspd_pkg::IMAGE_CENTER_DEF,
    parameter int MIN_TRUSTED_RANGE = vspd_pkg::MIN_TRUSTED_RANGE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [vspd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vspd_pkg::CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [vspd_pkg::OP_W-1:0]        i_operation,
    input  logic [vspd_pkg::TGT_W-1:0]       i_target_count,
    input  logic [vspd_pkg::X_W-1:0]         i_first_x,
    input  logic [vspd_pkg::X_W-1:0]         i_second_x,
    input  logic signed [vspd_pkg::POS_W-1:0] i_left_position,
    input  logic signed [vspd_pkg::POS_W-1:0] i_right_position,
    input  logic [vspd_pkg::RANGE_W-1:0]     i_sonar_range,

    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [vspd_pkg::DRIVE_W-1:0] o_left_drive,
    output logic signed [vspd_pkg::DRIVE_W-1:0] o_right_drive,
    output logic                             o_finished,
    output logic [vspd_pkg::REASON_W-1:0]    o_stop_reason
);
    import vspd_pkg::*;

    localparam int CEN2   = 2 * IMAGE_CENTER;
    localparam int OFF_CW = $clog2(CEN2 + 1024) + 1;
    localparam logic signed [OFF_CW-1:0] OFF_CEN = OFF_CW'(CEN2);
    localparam logic signed [OFF_CW-1:0] OFF_MAX = OFF_CW'(511);
    localparam logic signed [OFF_CW-1:0] OFF_MIN = OFF_CW'(-512);
    localparam int ISUM_W = INTEG_W + 2;
    localparam int QW     = MUL_P_W - 16;

    function automatic logic [DRIVE_W-1:0] clamp_q15(input logic signed [QW-1:0] v);
        logic [DRIVE_W-1:0] r;
        if (v > QW'(32767)) begin
            r = 16'h7fff;
        end else if (v < -QW'(32768)) begin
            r = 16'h8000;
        end else begin
            r = v[DRIVE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [DRIVE_W-1:0] neg_sat(input logic [DRIVE_W-1:0] v);
        logic [DRIVE_W-1:0] r;
        if (v == 16'h8000) begin
            r = 16'h7fff;
        end else begin
            r = DRIVE_W'(-$signed(v));
        end
        return r;
    endfunction

    t_cfg     cfg;
    t_mul_req mul_req;
    logic     mul_done;
    logic signed [MUL_P_W-1:0] mul_product;

    vspd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    vspd_digit_mult u_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mul_req),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    // control state
    t_state  r_state, n_state;
    t_term   r_term, n_term;
    logic    r_run_done, n_run_done;
    logic    r_trusted, n_trusted;
    t_reason r_held, n_held;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic    r_out_valid, n_out_valid;

    // controller state
    logic signed [INTEG_W-1:0] r_integral, n_integral;
    logic signed [OFF_W-1:0]   r_prev, n_prev;

    // captured word and working registers
    logic [OP_W-1:0]           r_op, n_op;
    logic [TGT_W-1:0]          r_tgt, n_tgt;
    logic [X_W-1:0]            r_x0, n_x0;
    logic [X_W-1:0]            r_x1, n_x1;
    logic signed [POS_W-1:0]   r_lpos, n_lpos;
    logic signed [POS_W-1:0]   r_rpos, n_rpos;
    logic [RANGE_W-1:0]        r_range, n_range;
    logic signed [OFF_W-1:0]   r_off, n_off;
    logic signed [DIFF_W-1:0]  r_diff, n_diff;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic signed [TURN_W-1:0]  r_turn, n_turn;
    logic [DRIVE_W-1:0]        r_res_left, n_res_left;
    logic [DRIVE_W-1:0]        r_res_right, n_res_right;
    logic                      r_res_fin, n_res_fin;
    t_reason                   r_res_why, n_res_why;
    logic [DRIVE_W-1:0]        r_out_left, n_out_left;
    logic [DRIVE_W-1:0]        r_out_right, n_out_right;
    logic                      r_out_fin, n_out_fin;
    t_reason                   r_out_why, n_out_why;

    // stop checks and offset
    logic [POS_W:0]            abs_l;
    logic [POS_W:0]            abs_r;
    logic [POS_W+1:0]          dist2;
    logic                      at_dist;
    logic                      near;
    logic                      timed;
    logic [X_W:0]              pos2;
    logic signed [OFF_CW-1:0]  off_wide;
    logic signed [OFF_W-1:0]   off_sat;
    logic signed [ISUM_W-1:0]  isum;
    logic signed [INTEG_W-1:0] isum_sat;
    logic signed [FAC_W-1:0]   fac_a;
    logic signed [FAC_W-1:0]   fac_b;
    logic signed [QW-1:0]      prod_q;

    always_comb begin
        abs_l   = r_lpos[POS_W-1] ? (POS_W+1)'(-r_lpos) : (POS_W+1)'(r_lpos);
        abs_r   = r_rpos[POS_W-1] ? (POS_W+1)'(-r_rpos) : (POS_W+1)'(r_rpos);
        dist2   = (POS_W+2)'(abs_l) + (POS_W+2)'(abs_r);
        at_dist = dist2 >= (POS_W+2)'({cfg.max_distance, 1'b0});
        near    = r_range <= cfg.stop_range;
        timed   = r_tick > TICK_W'(cfg.timeout_ticks);

        if (r_tgt == TGT_W'(1)) begin
            pos2 = {r_x0, 1'b0};
        end else begin
            pos2 = (X_W+1)'(r_x0) + (X_W+1)'(r_x1);
        end
        off_wide = $signed(OFF_CW'(pos2)) - OFF_CEN;
        if (off_wide > OFF_MAX) begin
            off_sat = OFF_W'(OFF_MAX);
        end else if (off_wide < OFF_MIN) begin
            off_sat = OFF_W'(OFF_MIN);
        end else begin
            off_sat = off_wide[OFF_W-1:0];
        end

        isum = ISUM_W'(r_integral) + ISUM_W'(r_off) + ISUM_W'(r_prev);
        if (isum > ISUM_W'(8388607)) begin
            isum_sat = INTEG_W'(8388607);
        end else if (isum < -ISUM_W'(8388608)) begin
            isum_sat = INTEG_W'(-8388608);
        end else begin
            isum_sat = isum[INTEG_W-1:0];
        end

        fac_a  = FAC_W'(TURN_LIM) - FAC_W'(r_turn);
        fac_b  = FAC_W'(TURN_LIM) + FAC_W'(r_turn);
        prod_q = mul_product[MUL_P_W-1:16];
    end

    always_comb begin
        n_state     = r_state;
        n_term      = r_term;
        n_run_done  = r_run_done;
        n_trusted   = r_trusted;
        n_held      = r_held;
        n_tick      = r_tick;
        n_integral  = r_integral;
        n_prev      = r_prev;
        n_op        = r_op;
        n_tgt       = r_tgt;
        n_x0        = r_x0;
        n_x1        = r_x1;
        n_lpos      = r_lpos;
        n_rpos      = r_rpos;
        n_range     = r_range;
        n_off       = r_off;
        n_diff      = r_diff;
        n_sum       = r_sum;
        n_turn      = r_turn;
        n_res_left  = r_res_left;
        n_res_right = r_res_right;
        n_res_fin   = r_res_fin;
        n_res_why   = r_res_why;
        n_out_left  = r_out_left;
        n_out_right = r_out_right;
        n_out_fin   = r_out_fin;
        n_out_why   = r_out_why;
        n_out_valid = r_out_valid && i_out_stall;
        o_in_stall  = (r_state != S_IDLE);

        mul_req.start        = 1'b0;
        mul_req.multiplicand = cfg.prop_gain;
        mul_req.operand      = {{2{r_off[OFF_W-1]}}, r_off, 12'b0};
        mul_req.digits       = DIGS_OFF;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_operation;
                    n_tgt   = i_target_count;
                    n_x0    = i_first_x;
                    n_x1    = i_second_x;
                    n_lpos  = i_left_position;
                    n_rpos  = i_right_position;
                    n_range = i_sonar_range;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_res_left  = '0;
                n_res_right = '0;
                n_res_fin   = 1'b0;
                n_res_why   = REASON_RUN;
                n_state     = S_OUT;
                if (r_op == OP_START) begin
                    n_integral = '0;
                    n_prev     = '0;
                    n_tick     = '0;
                    n_run_done = 1'b0;
                    n_held     = REASON_RUN;
                    n_trusted  = r_range >= RANGE_W'(MIN_TRUSTED_RANGE);
                end else if (r_run_done) begin
                    n_res_fin = 1'b1;
                    n_res_why = r_held;
                end else if (at_dist || (r_trusted && near) || timed) begin
                    n_run_done = 1'b1;
                    n_res_fin  = 1'b1;
                    if (at_dist) begin
                        n_held    = REASON_DIST;
                        n_res_why = REASON_DIST;
                    end else if (near) begin
                        n_held    = REASON_RANGE;
                        n_res_why = REASON_RANGE;
                    end else begin
                        n_held    = REASON_TIMEOUT;
                        n_res_why = REASON_TIMEOUT;
                    end
                end else begin
                    if (r_tick != '1) begin
                        n_tick = r_tick + TICK_W'(1);
                    end
                    if (r_tgt == '0) begin
                        n_res_left  = cfg.base_speed;
                        n_res_right = neg_sat(cfg.base_speed);
                    end else begin
                        n_off   = off_sat;
                        n_state = S_INTEG;
                    end
                end
            end
            S_INTEG: begin
                n_integral = isum_sat;
                n_diff     = DIFF_W'(r_off) - DIFF_W'(r_prev);
                n_prev     = r_off;
                n_sum      = '0;
                n_term     = TERM_PROP;
                n_state    = S_MUL_START;
            end
            S_MUL_START: begin
                mul_req.start = 1'b1;
                case (r_term)
                    TERM_INTEG: begin
                        mul_req.multiplicand = cfg.integ_gain;
                        mul_req.operand      = r_integral;
                        mul_req.digits       = DIGS_INTEG;
                    end
                    TERM_DERIV: begin
                        mul_req.multiplicand = cfg.deriv_gain;
                        mul_req.operand      = {r_diff[DIFF_W-1], r_diff, 12'b0};
                        mul_req.digits       = DIGS_OFF;
                    end
                    TERM_LEFT: begin
                        mul_req.multiplicand = MUL_M_W'($signed(cfg.base_speed));
                        mul_req.operand      = {fac_a, {DIG_W{1'b0}}};
                        mul_req.digits       = DIGS_FAC;
                    end
                    TERM_RIGHT: begin
                        mul_req.multiplicand = MUL_M_W'($signed(cfg.base_speed));
                        mul_req.operand      = {fac_b, {DIG_W{1'b0}}};
                        mul_req.digits       = DIGS_FAC;
                    end
                    default: begin
                        mul_req.multiplicand = cfg.prop_gain;
                    end
                endcase
                n_state = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (mul_done) begin
                    case (r_term)
                        TERM_PROP: begin
                            n_sum   = r_sum + SUM_W'(mul_product);
                            n_term  = TERM_INTEG;
                            n_state = S_MUL_START;
                        end
                        TERM_INTEG: begin
                            n_sum   = r_sum + SUM_W'(mul_product);
                            n_term  = TERM_DERIV;
                            n_state = S_MUL_START;
                        end
                        TERM_DERIV: begin
                            n_sum   = r_sum + SUM_W'(mul_product);
                            n_state = S_TURN;
                        end
                        TERM_LEFT: begin
                            n_res_left = clamp_q15(prod_q);
                            n_term     = TERM_RIGHT;
                            n_state    = S_MUL_START;
                        end
                        default: begin
                            n_res_right = neg_sat(clamp_q15(prod_q));
                            n_state     = S_OUT;
                        end
                    endcase
                end
            end
            S_TURN: begin
                if (r_sum > SUM_W'(TURN_LIM)) begin
                    n_turn = TURN_W'(TURN_LIM);
                end else if (r_sum < -SUM_W'(TURN_LIM)) begin
                    n_turn = -TURN_W'(TURN_LIM);
                end else begin
                    n_turn = r_sum[TURN_W-1:0];
                end
                n_term  = TERM_LEFT;
                n_state = S_MUL_START;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_left  = r_res_left;
                    n_out_right = r_res_right;
                    n_out_fin   = r_res_fin;
                    n_out_why   = r_res_why;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_term      <= TERM_PROP;
            r_run_done  <= 1'b1;
            r_trusted   <= 1'b1;
            r_held      <= REASON_RUN;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
            r_integral  <= '0;
            r_prev      <= '0;
        end else begin
            r_state     <= n_state;
            r_term      <= n_term;
            r_run_done  <= n_run_done;
            r_trusted   <= n_trusted;
            r_held      <= n_held;
            r_tick      <= n_tick;
            r_out_valid <= n_out_valid;
            r_integral  <= n_integral;
            r_prev      <= n_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_tgt       <= n_tgt;
        r_x0        <= n_x0;
        r_x1        <= n_x1;
        r_lpos      <= n_lpos;
        r_rpos      <= n_rpos;
        r_range     <= n_range;
        r_off       <= n_off;
        r_diff      <= n_diff;
        r_sum       <= n_sum;
        r_turn      <= n_turn;
        r_res_left  <= n_res_left;
        r_res_right <= n_res_right;
        r_res_fin   <= n_res_fin;
        r_res_why   <= n_res_why;
        r_out_left  <= n_out_left;
        r_out_right <= n_out_right;
        r_out_fin   <= n_out_fin;
        r_out_why   <= n_out_why;
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_drive  = r_out_left;
    assign o_right_drive = r_out_right;
    assign o_finished    = r_out_fin;
    assign o_stop_reason = r_out_why;

endmodule

// ===== rtl/core/vspd_checker.sv =====
// port-level checks on the vision steering pid drive
// depends on vspd_pkg; bound to vision_steering_pid_drive below

module vspd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [vspd_pkg::DRIVE_W-1:0]      o_left_drive,
    input logic [vspd_pkg::DRIVE_W-1:0]      o_right_drive,
    input logic                              o_finished,
    input logic [vspd_pkg::REASON_W-1:0]     o_stop_reason
);
    import vspd_pkg::*;

    // the block is always busy in the cycle after it accepts a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_left_drive)
            && $stable(o_right_drive) && $stable(o_finished) && $stable(o_stop_reason)))
        else $error("stalled result word changed");

    // a finished run drives nothing
    a_finished_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_finished) |-> (o_left_drive == '0 && o_right_drive == '0))
        else $error("nonzero drive on finished word");

    a_running_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_finished) |-> (o_stop_reason == REASON_RUN))
        else $error("stop reason set while running");

endmodule

bind vision_steering_pid_drive vspd_checker u_vspd_checker (.*);

// ===== sim/vspd_drive_checker.sv =====
`timescale 1ns / 100ps
// output word checker for the vision steering pid drive: mirrors the config registers,
// predicts each output word from the accepted input words and compares field by field
// depends on vspd_pkg for widths, operation, reason and register codes

module vspd_drive_checker
    import vspd_pkg::*;
#(
    parameter int IMAGE_CENTER      = IMAGE_CENTER_DEF,
    parameter int MIN_TRUSTED_RANGE = MIN_TRUSTED_RANGE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,

    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [OP_W-1:0]            i_operation,
    input  logic [TGT_W-1:0]           i_target_count,
    input  logic [X_W-1:0]             i_first_x,
    input  logic [X_W-1:0]             i_second_x,
    input  logic signed [POS_W-1:0]    i_left_position,
    input  logic signed [POS_W-1:0]    i_right_position,
    input  logic [RANGE_W-1:0]         i_sonar_range,

    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic signed [DRIVE_W-1:0]  i_left_drive,
    input  logic signed [DRIVE_W-1:0]  i_right_drive,
    input  logic                       i_finished,
    input  logic [REASON_W-1:0]        i_stop_reason,

    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left;
        logic signed [DRIVE_W-1:0] right;
        logic                      fin;
        t_reason                   why;
    } t_drive_word;

    t_drive_word expected_drives[$];

    logic signed [GAIN_W-1:0]  cfg_prop;
    logic signed [GAIN_W-1:0]  cfg_integ;
    logic signed [GAIN_W-1:0]  cfg_deriv;
    logic signed [SPEED_W-1:0] cfg_speed;
    logic [DIST_W-1:0]         cfg_maxdist;
    logic [RANGE_W-1:0]        cfg_stoprange;
    logic [TIMEOUT_W-1:0]      cfg_timeout;

    longint                    integ_acc;
    longint                    last_off;
    logic [TICK_W-1:0]         tick_ctr;
    logic                      sonar_ok;
    logic                      run_over;
    t_reason                   held_why;

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at output word %0d: %s", o_checked, msg);
        o_fail_count++;
    endtask

    task automatic predict_drive_word(
        input t_op                     op,
        input logic [TGT_W-1:0]        cnt,
        input logic [X_W-1:0]          x0,
        input logic [X_W-1:0]          x1,
        input logic signed [POS_W-1:0] lp,
        input logic signed [POS_W-1:0] rp,
        input logic [RANGE_W-1:0]      rng
    );
        longint      dist2;
        longint      pos2;
        longint      off;
        longint      turn;
        longint      speed;
        longint      a;
        longint      b;
        logic        at_dist;
        logic        near;
        logic        timed;
        t_drive_word w;

        w = '0;
        w.why = REASON_RUN;
        if (op == OP_START) begin
            integ_acc = 0;
            last_off  = 0;
            tick_ctr  = '0;
            run_over  = 1'b0;
            held_why  = REASON_RUN;
            sonar_ok  = (rng >= MIN_TRUSTED_RANGE);
        end else if (run_over) begin
            w.fin = 1'b1;
            w.why = held_why;
        end else begin
            dist2 = ((lp < 0) ? -longint'(lp) : longint'(lp))
                  + ((rp < 0) ? -longint'(rp) : longint'(rp));
            at_dist = (dist2 >= 2 * longint'(cfg_maxdist));
            near    = (rng <= cfg_stoprange);
            timed   = (tick_ctr > cfg_timeout);
            if (at_dist || (sonar_ok && near) || timed) begin
                // range wins over timeout even on an untrusted sonar
                if (at_dist)
                    held_why = REASON_DIST;
                else if (near)
                    held_why = REASON_RANGE;
                else
                    held_why = REASON_TIMEOUT;
                run_over = 1'b1;
                w.fin = 1'b1;
                w.why = held_why;
            end else begin
                if (tick_ctr != '1)
                    tick_ctr = tick_ctr + 1'b1;
                speed = longint'(cfg_speed);
                if (cnt == 0) begin
                    a = speed;
                    b = speed;
                end else begin
                    pos2 = (cnt == 1) ? 2 * longint'(x0) : longint'(x0) + longint'(x1);
                    off = clamp(pos2 - 2 * IMAGE_CENTER, -512, 511);
                    integ_acc = clamp(integ_acc + off + last_off, -8388608, 8388607);
                    turn = longint'(cfg_prop) * off
                         + longint'(cfg_integ) * integ_acc
                         + longint'(cfg_deriv) * (off - last_off);
                    turn = clamp(turn, -TURN_LIM, TURN_LIM);
                    last_off = off;
                    a = (speed * (TURN_LIM - turn)) >>> 16;
                    b = (speed * (TURN_LIM + turn)) >>> 16;
                end
                a = clamp(a, -32768, 32767);
                b = clamp(b, -32768, 32767);
                w.left  = DRIVE_W'(a);
                w.right = DRIVE_W'(clamp(-b, -32768, 32767));
            end
        end
        expected_drives.push_back(w);
    endtask

    task automatic check_drive_word();
        t_drive_word want;

        if (expected_drives.size() == 0) begin
            report_mismatch($sformatf("word with none expected, left %0d right %0d",
                                      i_left_drive, i_right_drive));
        end else begin
            want = expected_drives.pop_front();
            if (i_left_drive !== want.left)
                report_mismatch($sformatf("left drive %0d, want %0d", i_left_drive, want.left));
            if (i_right_drive !== want.right)
                report_mismatch($sformatf("right drive %0d, want %0d",
                                          i_right_drive, want.right));
            if (i_finished !== want.fin)
                report_mismatch($sformatf("finished %0d, want %0d", i_finished, want.fin));
            if (i_stop_reason !== want.why)
                report_mismatch($sformatf("stop reason %0d, want %0d",
                                          i_stop_reason, want.why));
            o_checked++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_prop      = '0;
            cfg_integ     = '0;
            cfg_deriv     = '0;
            cfg_speed     = '0;
            cfg_maxdist   = '0;
            cfg_stoprange = '0;
            cfg_timeout   = '0;
            integ_acc     = 0;
            last_off      = 0;
            tick_ctr      = '0;
            sonar_ok      = 1'b1;
            run_over      = 1'b1;
            held_why      = REASON_RUN;
            expected_drives.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PROP:    cfg_prop      = i_cfg_data[GAIN_W-1:0];
                    CFG_INTEG:   cfg_integ     = i_cfg_data[GAIN_W-1:0];
                    CFG_DERIV:   cfg_deriv     = i_cfg_data[GAIN_W-1:0];
                    CFG_SPEED:   cfg_speed     = i_cfg_data[SPEED_W-1:0];
                    CFG_MAXDIST: cfg_maxdist   = i_cfg_data[DIST_W-1:0];
                    CFG_STOPRNG: cfg_stoprange = i_cfg_data[RANGE_W-1:0];
                    CFG_TIMEOUT: cfg_timeout   = i_cfg_data[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall)
                check_drive_word();
            if (i_in_valid && !i_in_stall)
                predict_drive_word(t_op'(i_operation), i_target_count, i_first_x, i_second_x,
                                   i_left_position, i_right_position, i_sonar_range);
        end
        o_pending = expected_drives.size();
    end

endmodule

// ===== sim/tb_vision_steering_pid_drive.sv =====
`timescale 1ns / 100ps
// testbench top for vision_steering_pid_drive: drives config writes, directed and random
// words with sender gaps and receiver stalls, and gives the verdict
// depends on vspd_pkg, the block and vspd_drive_checker

module tb_vision_steering_pid_drive;

    import vspd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                      clk = 1'b0;
    logic                      rst_n;

    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    logic                      in_valid;
    logic                      in_stall;
    logic [OP_W-1:0]           operation;
    logic [TGT_W-1:0]          target_count;
    logic [X_W-1:0]            first_x;
    logic [X_W-1:0]            second_x;
    logic signed [POS_W-1:0]   left_pos;
    logic signed [POS_W-1:0]   right_pos;
    logic [RANGE_W-1:0]        sonar_range;

    logic                      out_valid;
    logic                      out_stall;
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic                      finished;
    logic [REASON_W-1:0]       stop_reason;

    int fail_count;
    int pending;
    int checked;
    int gap_pct;
    int stall_pct;
    int words_sent;
    int settings_used;
    int cycle_ctr;
    int cur_maxd;
    int cur_stopr;

    vision_steering_pid_drive dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_operation      (operation),
        .i_target_count   (target_count),
        .i_first_x        (first_x),
        .i_second_x       (second_x),
        .i_left_position  (left_pos),
        .i_right_position (right_pos),
        .i_sonar_range    (sonar_range),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_left_drive     (left_drive),
        .o_right_drive    (right_drive),
        .o_finished       (finished),
        .o_stop_reason    (stop_reason)
    );

    vspd_drive_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_operation      (operation),
        .i_target_count   (target_count),
        .i_first_x        (first_x),
        .i_second_x       (second_x),
        .i_left_position  (left_pos),
        .i_right_position (right_pos),
        .i_sonar_range    (sonar_range),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_left_drive     (left_drive),
        .i_right_drive    (right_drive),
        .i_finished       (finished),
        .i_stop_reason    (stop_reason),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk) begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        cycle_ctr <= cycle_ctr + 1;
        if (cycle_ctr > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_ctr, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_word(
        input t_op                     op,
        input logic [TGT_W-1:0]        cnt,
        input logic [X_W-1:0]          x0,
        input logic [X_W-1:0]          x1,
        input logic signed [POS_W-1:0] lp,
        input logic signed [POS_W-1:0] rp,
        input logic [RANGE_W-1:0]      rng
    );
        @(negedge clk);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        target_count <= cnt;
        first_x      <= x0;
        second_x     <= x1;
        left_pos     <= lp;
        right_pos    <= rp;
        sonar_range  <= rng;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    // sender holds off until every expected word has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_settings(
        input logic [GAIN_W-1:0]    prop,
        input logic [GAIN_W-1:0]    integ,
        input logic [GAIN_W-1:0]    deriv,
        input logic [SPEED_W-1:0]   speed,
        input logic [DIST_W-1:0]    maxd,
        input logic [RANGE_W-1:0]   stopr,
        input logic [TIMEOUT_W-1:0] tmo
    );
        write_reg(CFG_PROP,    CFG_DATA_W'(prop));
        write_reg(CFG_INTEG,   CFG_DATA_W'(integ));
        write_reg(CFG_DERIV,   CFG_DATA_W'(deriv));
        write_reg(CFG_SPEED,   CFG_DATA_W'(speed));
        write_reg(CFG_MAXDIST, CFG_DATA_W'(maxd));
        write_reg(CFG_STOPRNG, CFG_DATA_W'(stopr));
        write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_maxd  = int'(maxd);
        cur_stopr = int'(stopr);
        settings_used++;
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain(input int span);
        int v;
        if ($urandom_range(99) < 75) begin
            v = int'($urandom_range(0, 2 * span)) - span;
            return GAIN_W'(v);
        end
        return GAIN_W'($urandom);
    endfunction

    function automatic logic [X_W-1:0] pick_x();
        if ($urandom_range(99) < 85)
            return X_W'($urandom_range(0, 319));
        return X_W'($urandom);
    endfunction

    // mostly inside the distance limit, sometimes anywhere
    function automatic logic signed [POS_W-1:0] pick_position();
        int mag;
        if ($urandom_range(99) < 10)
            return POS_W'($urandom);
        mag = int'($urandom_range(0, (cur_maxd * 3) / 4));
        return ($urandom_range(1) != 0) ? POS_W'(-mag) : POS_W'(mag);
    endfunction

    initial begin
        int                   phase;
        int                   phase_start;
        int                   run_len;
        logic                 paused;
        logic [RANGE_W-1:0]   rng;

        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        operation    = OP_START;
        target_count = '0;
        first_x      = '0;
        second_x     = '0;
        left_pos     = '0;
        right_pos    = '0;
        sonar_range  = '0;
        out_stall    = 1'b0;
        gap_pct      = 0;
        stall_pct    = 0;
        cur_maxd     = 0;
        cur_stopr    = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // reset defaults: tick with no run, then a run that stops on distance at once
        send_word(OP_TICK, 2'd3, 9'd511, 9'd511, 20'sh7FFFF, 20'sh80000, 10'd1023);
        send_word(OP_START, 2'd0, 9'd0, 9'd0, 20'sd0, 20'sd0, 10'd0);
        send_word(OP_TICK, 2'd1, 9'd100, 9'd0, 20'sd0, 20'sd0, 10'd500);
        send_word(OP_TICK, 2'd0, 9'd0, 9'd0, 20'sd0, 20'sd0, 10'd500);
        drain_results();

        load_settings(GAIN_W'(200), GAIN_W'(3), GAIN_W'(-150), SPEED_W'(16384),
                      DIST_W'(100000), RANGE_W'(30), TIMEOUT_W'(6));
        // untrusted sonar: near readings do not stop, the offset reaches its upper rail
        send_word(OP_START, 2'd0, 9'd0, 9'd0, 20'sd0, 20'sd0, 10'd14);
        send_word(OP_TICK, 2'd0, 9'd0, 9'd0, 20'sd1000, -20'sd1000, 10'd5);
        send_word(OP_TICK, 2'd1, 9'd319, 9'd0, 20'sd0, 20'sd0, 10'd5);
        send_word(OP_TICK, 2'd1, 9'd0, 9'd319, 20'sd0, 20'sd0, 10'd5);
        send_word(OP_TICK, 2'd2, 9'd511, 9'd511, 20'sd0, 20'sd0, 10'd5);
        send_word(OP_TICK, 2'd3, 9'd160, 9'd160, 20'sd0, 20'sd0, 10'd5);
        send_word(OP_TICK, 2'd2, 9'd0, 9'd0, 20'sd0, 20'sd0, 10'd5);
        send_word(OP_TICK, 2'd1, 9'd400, 9'd0, 20'sd0, 20'sd0, 10'd5);
        // timer runs out with an untrusted near range: reason is range
        send_word(OP_TICK, 2'd1, 9'd200, 9'd0, 20'sd0, 20'sd0, 10'd5);
        // distance exactly at the limit beats a trusted range at the stop value
        send_word(OP_START, 2'd0, 9'd0, 9'd0, 20'sd0, 20'sd0, 10'd15);
        send_word(OP_TICK, 2'd1, 9'd100, 9'd0, 20'sd200000, 20'sd0, 10'd30);
        send_word(OP_START, 2'd0, 9'd0, 9'd0, 20'sd0, 20'sd0, 10'd1023);
        send_word(OP_TICK, 2'd1, 9'd100, 9'd0, -20'sd100000, -20'sd99999, 10'd31);
        send_word(OP_TICK, 2'd1, 9'd100, 9'd0, 20'sd0, 20'sd0, 10'd30);
        send_word(OP_TICK, 2'd2, 9'd300, 9'd20, 20'sd0, 20'sd0, 10'd1023);
        drain_results();

        load_settings(GAIN_W'(131071), GAIN_W'(-131072), GAIN_W'(-131072),
                      SPEED_W'(-32768), DIST_W'(524287), RANGE_W'(0), TIMEOUT_W'(0));
        send_word(OP_START, 2'd0, 9'd0, 9'd0, 20'sd0, 20'sd0, 10'd1023);
        send_word(OP_TICK, 2'd1, 9'd319, 9'd0, 20'sh80000, 20'sd0, 10'd1);
        send_word(OP_TICK, 2'd2, 9'd0, 9'd511, 20'sd0, 20'sd0, 10'd1);
        send_word(OP_TICK, 2'd1, 9'd10, 9'd0, 20'sh7FFFF, -20'sd524287, 10'd1);

        for (phase = 0; phase < 5; phase++) begin
            drain_results();
            if (phase == 2)
                load_settings(GAIN_W'(-131072), GAIN_W'(131071), GAIN_W'(131071),
                              SPEED_W'(32767), DIST_W'(524287), RANGE_W'(1023),
                              TIMEOUT_W'(65535));
            else
                load_settings(pick_gain(600), pick_gain(40), pick_gain(600),
                              SPEED_W'($urandom),
                              ($urandom_range(99) < 70) ? DIST_W'($urandom_range(2000, 300000))
                                  : (($urandom_range(99) < 50) ? DIST_W'($urandom_range(0, 1000))
                                                               : DIST_W'($urandom)),
                              ($urandom_range(99) < 80) ? RANGE_W'($urandom_range(0, 40))
                                                        : RANGE_W'($urandom),
                              ($urandom_range(99) < 70) ? TIMEOUT_W'($urandom_range(0, 40))
                                                        : TIMEOUT_W'($urandom));
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 72; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 72; end
                default: begin gap_pct = 11; stall_pct = 11; end
            endcase
            paused = 1'b0;
            phase_start = words_sent;
            while (words_sent - phase_start < 100) begin
                if (!paused && words_sent - phase_start >= 50) begin
                    drain_results();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 10) begin
                    send_word(t_op'($urandom_range(1)), TGT_W'($urandom), X_W'($urandom),
                              X_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                              RANGE_W'($urandom));
                end else begin
                    send_word(OP_START, TGT_W'($urandom), pick_x(), pick_x(),
                              pick_position(), pick_position(),
                              ($urandom_range(99) < 85)
                                  ? RANGE_W'($urandom_range(MIN_TRUSTED_RANGE_DEF, 1023))
                                  : RANGE_W'($urandom_range(0, MIN_TRUSTED_RANGE_DEF - 1)));
                    run_len = $urandom_range(1, 30);
                    repeat (run_len) begin
                        if (cur_stopr < 1023 && $urandom_range(99) < 85)
                            rng = RANGE_W'($urandom_range(cur_stopr + 1, 1023));
                        else
                            rng = RANGE_W'($urandom);
                        send_word(OP_TICK,
                                  ($urandom_range(99) < 80) ? TGT_W'($urandom_range(1, 2))
                                                            : TGT_W'($urandom),
                                  pick_x(), pick_x(), pick_position(), pick_position(), rng);
                    end
                end
            end
        end

        drain_results();
        repeat (40) @(negedge clk);
        $display("summary: %0d words over %0d register settings, %0d output words checked",
                 words_sent, settings_used, checked);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/vspd_pkg.sv
rtl/core/vspd_cfg_regs.sv
rtl/core/vspd_digit_mult.sv
rtl/core/vision_steering_pid_drive.sv
rtl/core/vspd_checker.sv
sim/vspd_drive_checker.sv
sim/tb_vision_steering_pid_drive.sv
